// ----- sv/ethernet_ipv4_frame_classifier_defines.svh -----
// assertion macros shared by the classifier rtl
`ifndef ETHERNET_IPV4_FRAME_CLASSIFIER_DEFINES_SVH
`define ETHERNET_IPV4_FRAME_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define EIC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define EIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define EIC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/eic_pkg.sv -----
package eic_pkg;

	localparam int POS_W = 11;

	// frames are judged on their first MAX_FRAME_BYTES bytes
	localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 11'd1514;

	// byte positions in the frame
	localparam logic [POS_W-1:0] POS_DEST_END = 11'd6;
	localparam logic [POS_W-1:0] POS_TYPE_HI  = 11'd12;
	localparam logic [POS_W-1:0] POS_TYPE_LO  = 11'd13;
	localparam logic [POS_W-1:0] POS_IP_START = 11'd14;
	localparam logic [POS_W-1:0] POS_FRAG_HI  = 11'd20;
	localparam logic [POS_W-1:0] POS_FRAG_LO  = 11'd21;
	localparam logic [POS_W-1:0] POS_PROTO    = 11'd23;
	localparam logic [POS_W-1:0] POS_CSUM_HI  = 11'd24;
	localparam logic [POS_W-1:0] POS_CSUM_LO  = 11'd25;

	// length thresholds
	localparam logic [POS_W-1:0] LEN_ETH_HDR  = 11'd14;
	localparam logic [POS_W-1:0] LEN_FRAG     = 11'd22;
	localparam logic [POS_W-1:0] LEN_MIN_HDR  = 11'd26;

	localparam logic [7:0]  BCAST_BYTE   = 8'hff;
	localparam logic [7:0]  TYPE_HI_IP   = 8'h08;
	localparam logic [7:0]  TYPE_LO_ARP  = 8'h06;
	localparam logic [7:0]  TYPE_LO_IPV4 = 8'h00;
	localparam logic [15:0] FRAG_MASK    = 16'h3fff;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;

	typedef enum logic [3:0] {
		CLS_NONIP       = 4'd0,
		CLS_ARP_BCAST   = 4'd1,
		CLS_OTHER_BCAST = 4'd2,
		CLS_NONIPV4     = 4'd3,
		CLS_FRAGMENT    = 4'd4,
		CLS_BADSUM      = 4'd5,
		CLS_ICMP        = 4'd6,
		CLS_UDP         = 4'd7,
		CLS_OTHERPROTO  = 4'd8,
		CLS_TRUNCATED   = 4'd9
	} frame_class_t;

	// header fields collected so far in the current frame
	typedef struct packed {
		logic [POS_W-1:0] length;
		logic             dest_all_ones;
		logic [15:0]      type_word;
		logic [3:0]       ihl;
		logic [15:0]      frag;
		logic [7:0]       proto;
		logic [15:0]      stored_csum;
		logic [15:0]      running_sum;
	} frame_view_t;

	typedef struct packed {
		frame_class_t cls;
		logic [7:0]   proto;
		logic [3:0]   ihl;
		logic [15:0]  csum;
	} class_result_t;

	// ones' complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ----- sv/eic_tracker.sv -----
module eic_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           frame_byte,
	input  logic                 end_of_frame,
	output eic_pkg::frame_view_t view
);

	eic_pkg::frame_view_t                cur_q;
	eic_pkg::frame_view_t                nxt;
	logic [7:0]                          hold_q;
	logic [7:0]                          hold_nxt;
	logic [3:0]                          ihl_eff;
	logic [eic_pkg::POS_W-1:0]           pos;
	logic [eic_pkg::POS_W-1:0]           off;
	logic                                in_hdr;
	logic [7:0]                          sum_byte;

	assign pos      = cur_q.length;
	// the ihl byte already counts for its own position
	assign ihl_eff  = (pos == eic_pkg::POS_IP_START) ? frame_byte[3:0] : cur_q.ihl;
	assign off      = pos - eic_pkg::POS_IP_START;
	assign in_hdr   = (pos >= eic_pkg::POS_IP_START) &&
		(off < {5'd0, ihl_eff, 2'b00});
	// checksum field is summed as zero
	assign sum_byte = (pos == eic_pkg::POS_CSUM_HI || pos == eic_pkg::POS_CSUM_LO) ?
		8'd0 : frame_byte;

	always_comb begin
		nxt      = cur_q;
		hold_nxt = hold_q;
		if (pos < eic_pkg::MAX_FRAME_BYTES) begin
			nxt.length = pos + 11'd1;
			if (pos < eic_pkg::POS_DEST_END && frame_byte != eic_pkg::BCAST_BYTE)
				nxt.dest_all_ones = 1'b0;
			if (pos == eic_pkg::POS_TYPE_HI) nxt.type_word[15:8] = frame_byte;
			if (pos == eic_pkg::POS_TYPE_LO) nxt.type_word[7:0] = frame_byte;
			if (pos == eic_pkg::POS_IP_START) nxt.ihl = frame_byte[3:0];
			if (pos == eic_pkg::POS_FRAG_HI) nxt.frag[15:8] = frame_byte;
			if (pos == eic_pkg::POS_FRAG_LO) nxt.frag[7:0] = frame_byte;
			if (pos == eic_pkg::POS_PROTO) nxt.proto = frame_byte;
			if (pos == eic_pkg::POS_CSUM_HI) nxt.stored_csum[15:8] = frame_byte;
			if (pos == eic_pkg::POS_CSUM_LO) nxt.stored_csum[7:0] = frame_byte;
			if (in_hdr) begin
				if (!off[0]) begin
					hold_nxt = sum_byte;
				end else begin
					nxt.running_sum = eic_pkg::oc_add(cur_q.running_sum,
						{hold_q, sum_byte});
				end
			end
		end
	end

	assign view = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.length        <= '0;
			cur_q.dest_all_ones <= 1'b1;
			cur_q.type_word     <= '0;
			cur_q.ihl           <= '0;
			cur_q.frag          <= '0;
			cur_q.proto         <= '0;
			cur_q.stored_csum   <= '0;
			cur_q.running_sum   <= '0;
			hold_q              <= '0;
		end else if (take) begin
			if (end_of_frame) begin
				cur_q.length        <= '0;
				cur_q.dest_all_ones <= 1'b1;
				cur_q.type_word     <= '0;
				cur_q.ihl           <= '0;
				cur_q.frag          <= '0;
				cur_q.proto         <= '0;
				cur_q.stored_csum   <= '0;
				cur_q.running_sum   <= '0;
				hold_q              <= '0;
			end else begin
				cur_q  <= nxt;
				hold_q <= hold_nxt;
			end
		end
	end

endmodule

// ----- sv/eic_classify.sv -----
module eic_classify (
	input  eic_pkg::frame_view_t   view,
	output eic_pkg::class_result_t result
);

	logic [eic_pkg::POS_W-1:0] hdr_end;
	logic [eic_pkg::POS_W-1:0] need;
	logic [15:0]               csum;

	assign hdr_end = eic_pkg::POS_IP_START + {5'd0, view.ihl, 2'b00};
	assign need    = (hdr_end < eic_pkg::LEN_MIN_HDR) ? eic_pkg::LEN_MIN_HDR : hdr_end;
	assign csum    = ~view.running_sum;

	always_comb begin
		result.proto = view.proto;
		result.ihl   = view.ihl;
		result.csum  = 16'd0;
		if (view.length < eic_pkg::LEN_ETH_HDR) begin
			result.cls = eic_pkg::CLS_TRUNCATED;
		end else if (view.type_word[15:8] != eic_pkg::TYPE_HI_IP) begin
			result.cls = eic_pkg::CLS_NONIP;
		end else if (view.dest_all_ones) begin
			result.cls = (view.type_word[7:0] == eic_pkg::TYPE_LO_ARP) ?
				eic_pkg::CLS_ARP_BCAST : eic_pkg::CLS_OTHER_BCAST;
		end else if (view.type_word[7:0] != eic_pkg::TYPE_LO_IPV4) begin
			result.cls = eic_pkg::CLS_NONIPV4;
		end else if (view.length < eic_pkg::LEN_FRAG) begin
			result.cls = eic_pkg::CLS_TRUNCATED;
		end else if ((view.frag & eic_pkg::FRAG_MASK) != 16'd0) begin
			result.cls = eic_pkg::CLS_FRAGMENT;
		end else if (view.length < need) begin
			result.cls = eic_pkg::CLS_TRUNCATED;
		end else begin
			result.csum = csum;
			if (csum != view.stored_csum)
				result.cls = eic_pkg::CLS_BADSUM;
			else if (view.proto == eic_pkg::PROTO_ICMP)
				result.cls = eic_pkg::CLS_ICMP;
			else if (view.proto == eic_pkg::PROTO_UDP)
				result.cls = eic_pkg::CLS_UDP;
			else
				result.cls = eic_pkg::CLS_OTHERPROTO;
		end
	end

endmodule

// ----- sv/ethernet_ipv4_frame_classifier.sv -----
// Ethernet/IPv4 receive classifier. Frame bytes enter one per transfer in wire
// order, tlast on the final byte; each frame yields exactly one result transfer,
// issued for its last byte, carrying the frame class, the IP protocol byte, the
// IHL nibble and the complemented header sum (zero unless the class is bad
// checksum, ICMP, UDP or other protocol). Throughput is one byte per clock: a
// byte is registered, then one pass of tracking and classification logic writes
// the result register, so a result is offered once the input register has passed
// its last byte on. Input is held back only when a last byte finds the result
// register still full and the sink not ready. Bytes from position 1514 on
// (counting from zero) are ignored, so a frame is judged on its first 1514 bytes.
`include "ethernet_ipv4_frame_classifier_defines.svh"

module ethernet_ipv4_frame_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// frame byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
	input  logic        s_axis_tlast,   // end_of_frame
	// classification results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [3:0] frame_class, [11:4] ip_protocol,
	                                    // [15:12] header_words,
	                                    // [31:16] computed_checksum
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic                   out_valid_q;
	eic_pkg::class_result_t out_q;

	eic_pkg::frame_view_t   view;
	eic_pkg::class_result_t result;
	logic                   advance;

	// assertion helpers
	logic                   last_blocked;
	logic                   csum_class;
	logic                   early_csum_ok;

	// a byte moves on unless it is a last byte and the result slot is blocked
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// header field tracking, state updated as each byte is consumed
	eic_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (advance),
		.frame_byte   (byte_s1),
		.end_of_frame (last_s1),
		.view         (view)
	);

	// classification of the state including the current byte
	eic_classify u_classify (
		.view   (view),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.csum, out_q.ihl, out_q.proto, out_q.cls};

	assign last_blocked  = valid_s1 && last_s1 && out_valid_q && !m_axis_tready;
	// bad checksum through other protocol carry the computed sum
	assign csum_class    = (out_q.cls >= eic_pkg::CLS_BADSUM) &&
		(out_q.cls <= eic_pkg::CLS_OTHERPROTO);
	assign early_csum_ok = !m_axis_tvalid || csum_class || (out_q.csum == 16'd0);

	// a consumed last byte always lands in the result register
	`EIC_ASSERT(a_last_loads_result, clk, arst_n, (advance && last_s1) |=> m_axis_tvalid, "last byte lost")

	// a blocked last byte must stall the input side
	`EIC_ASSERT(a_blocked_last_stalls, clk, arst_n, last_blocked |-> !s_axis_tready, "input not stalled")

	// an empty input register can always take a byte
	`EIC_ASSERT_ALWAYS(a_empty_takes_byte, clk, !valid_s1 |-> s_axis_tready, "empty input not ready")

	// checksum is reported only for frames that reached the checksum test
	`EIC_ASSERT(a_csum_zero_early, clk, arst_n, early_csum_ok, "checksum reported for early class")

endmodule

// ----- bench/tb_ethernet_ipv4_frame_classifier.sv -----
module tb_ethernet_ipv4_frame_classifier;

	// cycles with no transfer on either side before the run is given up
	localparam int STALL_LIMIT = 2000;
	// wait after the last result so that any stray result can show
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] frame_byte
	logic        s_axis_tlast = 1'b0;    // end_of_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [3:0] frame_class, [11:4] ip_protocol,
	                                     // [15:12] header_words,
	                                     // [31:16] computed_checksum

	ethernet_ipv4_frame_classifier uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// classes predicted for frames whose last byte went in, oldest first
	eic_pkg::class_result_t pending_classes[$];
	int            error_count = 0;
	int            bytes_sent = 0;
	int            frames_sent = 0;
	int            stall_cycles = 0;

	// idle rates in percent for the byte source and the result sink
	int            send_idle_pct = 0;
	int            sink_stall_pct = 0;

	// frame under construction, sent front to back
	logic [7:0]    frame_buf[$];

	// shadow of the header tracking done by the classifier
	int            trk_pos;
	bit            trk_bcast;
	logic [15:0]   trk_type;
	logic [3:0]    trk_ihl;
	logic [15:0]   trk_frag;
	logic [7:0]    trk_proto;
	logic [15:0]   trk_stored;
	logic [15:0]   trk_sum;
	logic [7:0]    trk_hold;

	// ones' complement add, end-around carry
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	task automatic clear_tracker();
		trk_pos = 0;
		trk_bcast = 1'b1;
		trk_type = '0;
		trk_ihl = '0;
		trk_frag = '0;
		trk_proto = '0;
		trk_stored = '0;
		trk_sum = '0;
		trk_hold = '0;
	endtask

	// advance the shadow by one accepted byte; the last byte yields a class
	task automatic track_frame_byte(input logic [7:0] b, input logic last);
		int                     off;
		int                     need;
		logic [7:0]             v;
		logic [15:0]            csum;
		eic_pkg::class_result_t r;
		if (trk_pos < eic_pkg::MAX_FRAME_BYTES) begin
			if (trk_pos < eic_pkg::POS_DEST_END && b != eic_pkg::BCAST_BYTE)
				trk_bcast = 1'b0;
			case (trk_pos)
				eic_pkg::POS_TYPE_HI: trk_type[15:8] = b;
				eic_pkg::POS_TYPE_LO: trk_type[7:0] = b;
				eic_pkg::POS_IP_START: trk_ihl = b[3:0];
				eic_pkg::POS_FRAG_HI: trk_frag[15:8] = b;
				eic_pkg::POS_FRAG_LO: trk_frag[7:0] = b;
				eic_pkg::POS_PROTO: trk_proto = b;
				eic_pkg::POS_CSUM_HI: trk_stored[15:8] = b;
				eic_pkg::POS_CSUM_LO: trk_stored[7:0] = b;
				default: ;
			endcase
			// header sum over 4*ihl bytes, checksum bytes read as zero
			if (trk_pos >= eic_pkg::POS_IP_START) begin
				off = trk_pos - eic_pkg::POS_IP_START;
				if (off < 4 * trk_ihl) begin
					v = (trk_pos == eic_pkg::POS_CSUM_HI || trk_pos == eic_pkg::POS_CSUM_LO) ?
						8'h00 : b;
					if (off % 2 == 0)
						trk_hold = v;
					else
						trk_sum = ones_add(trk_sum, {trk_hold, v});
				end
			end
			trk_pos++;
		end
		if (last) begin
			need = eic_pkg::LEN_ETH_HDR + 4 * trk_ihl;
			if (need < eic_pkg::LEN_MIN_HDR)
				need = eic_pkg::LEN_MIN_HDR;
			csum = ~trk_sum;
			r.proto = trk_proto;
			r.ihl = trk_ihl;
			r.csum = '0;
			// same precedence as the classifier: first matching rule wins
			if (trk_pos < eic_pkg::LEN_ETH_HDR) begin
				r.cls = eic_pkg::CLS_TRUNCATED;
			end else if (trk_type[15:8] != eic_pkg::TYPE_HI_IP) begin
				r.cls = eic_pkg::CLS_NONIP;
			end else if (trk_bcast) begin
				if (trk_type[7:0] == eic_pkg::TYPE_LO_ARP)
					r.cls = eic_pkg::CLS_ARP_BCAST;
				else
					r.cls = eic_pkg::CLS_OTHER_BCAST;
			end else if (trk_type[7:0] != eic_pkg::TYPE_LO_IPV4) begin
				r.cls = eic_pkg::CLS_NONIPV4;
			end else if (trk_pos < eic_pkg::LEN_FRAG) begin
				r.cls = eic_pkg::CLS_TRUNCATED;
			end else if ((trk_frag & eic_pkg::FRAG_MASK) != 0) begin
				r.cls = eic_pkg::CLS_FRAGMENT;
			end else if (trk_pos < need) begin
				r.cls = eic_pkg::CLS_TRUNCATED;
			end else begin
				r.csum = csum;
				if (csum != trk_stored)
					r.cls = eic_pkg::CLS_BADSUM;
				else if (trk_proto == eic_pkg::PROTO_ICMP)
					r.cls = eic_pkg::CLS_ICMP;
				else if (trk_proto == eic_pkg::PROTO_UDP)
					r.cls = eic_pkg::CLS_UDP;
				else
					r.cls = eic_pkg::CLS_OTHERPROTO;
			end
			pending_classes.push_back(r);
			clear_tracker();
		end
	endtask

	// one byte transfer; called at a rising edge, returns at the edge it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		track_frame_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	// hold the source off until every predicted class has come back
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_classes.size() != 0);
	endtask

	task automatic cut_frame(input int n);
		while (frame_buf.size() > n)
			void'(frame_buf.pop_back());
	endtask

	// ethernet + ipv4 header with random content; checksum right unless sum_ok is 0
	task automatic build_ipv4(input bit bcast, input logic [7:0] type_lo,
			input logic [3:0] ihl, input logic [15:0] frag, input logic [7:0] proto,
			input bit sum_ok, input int payload_len);
		int          i;
		int          hdr_len;
		logic [15:0] sum;
		frame_buf.delete();
		for (i = 0; i < 6; i++)
			frame_buf.push_back(bcast ? eic_pkg::BCAST_BYTE : 8'($urandom));
		// make sure a unicast destination really is not all ones
		if (!bcast)
			frame_buf[$urandom_range(0, 5)] = 8'($urandom_range(0, 254));
		for (i = 0; i < 6; i++)
			frame_buf.push_back(8'($urandom));
		frame_buf.push_back(eic_pkg::TYPE_HI_IP);
		frame_buf.push_back(type_lo);
		// short ihl still carries the fixed fields up to the checksum
		hdr_len = (ihl < 5) ? 20 : 4 * ihl;
		for (i = 0; i < hdr_len; i++)
			frame_buf.push_back(8'($urandom));
		frame_buf[eic_pkg::POS_IP_START] = {4'h4, ihl};
		frame_buf[eic_pkg::POS_FRAG_HI] = frag[15:8];
		frame_buf[eic_pkg::POS_FRAG_LO] = frag[7:0];
		frame_buf[eic_pkg::POS_PROTO] = proto;
		frame_buf[eic_pkg::POS_CSUM_HI] = 8'h00;
		frame_buf[eic_pkg::POS_CSUM_LO] = 8'h00;
		sum = '0;
		for (i = 0; i < 4 * ihl; i += 2)
			sum = ones_add(sum, {frame_buf[eic_pkg::POS_IP_START + i],
				frame_buf[eic_pkg::POS_IP_START + i + 1]});
		sum = ~sum;
		if (!sum_ok)
			sum ^= 16'($urandom_range(1, 65535));
		frame_buf[eic_pkg::POS_CSUM_HI] = sum[15:8];
		frame_buf[eic_pkg::POS_CSUM_LO] = sum[7:0];
		for (i = 0; i < payload_len; i++)
			frame_buf.push_back(8'($urandom));
	endtask

	// a frame for each class but truncated, plus the broadcast and type corner cases
	task automatic run_class_frames();
		int i;
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_ICMP, 1'b1, 0);
		send_frame();
		// don't-fragment flag lies outside the fragment mask
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h4000, eic_pkg::PROTO_UDP, 1'b1, 0);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd15, 16'h0000, 8'd6, 1'b1, 0);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b0, 0);
		send_frame();
		// fragments are decided once the flags word is in
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h2000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(22);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0001, eic_pkg::PROTO_ICMP, 1'b1, 0);
		cut_frame(22);
		send_frame();
		// the remaining classes here are decided by the ethernet header alone
		build_ipv4(1'b1, eic_pkg::TYPE_LO_ARP, 4'd5, 16'h0000, 8'd0, 1'b1, 0);
		cut_frame(14);
		send_frame();
		build_ipv4(1'b1, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(14);
		send_frame();
		build_ipv4(1'b0, 8'h66, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(14);
		send_frame();
		// arp type but one destination byte short of broadcast
		build_ipv4(1'b1, eic_pkg::TYPE_LO_ARP, 4'd5, 16'h0000, 8'd0, 1'b1, 0);
		frame_buf[5] = 8'hfe;
		cut_frame(14);
		send_frame();
		// ipv6-style type word
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		frame_buf[eic_pkg::POS_TYPE_HI] = 8'h86;
		frame_buf[eic_pkg::POS_TYPE_LO] = 8'hdd;
		cut_frame(14);
		send_frame();
		// all-zero and all-ones frames
		frame_buf.delete();
		for (i = 0; i < 16; i++)
			frame_buf.push_back(8'h00);
		send_frame();
		frame_buf.delete();
		for (i = 0; i < 16; i++)
			frame_buf.push_back(8'hff);
		send_frame();
	endtask

	// ihl below five: the sum covers fewer bytes than the fixed fields
	task automatic run_short_ihl_frames();
		int i;
		for (i = 0; i < 5; i++) begin
			build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'(i), 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
			// just long enough for the header to count as complete
			cut_frame((i == 4) ? 30 : 26);
			send_frame();
		end
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd0, 16'h0000, eic_pkg::PROTO_ICMP, 1'b0, 0);
		cut_frame(26);
		send_frame();
	endtask

	// frames that end at each of the length thresholds
	task automatic run_truncated_frames();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(1);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(13);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(14);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(21);
		send_frame();
		// fragment is decided before the header is complete
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h1fff, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(22);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd2, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(25);
		send_frame();
		build_ipv4(1'b0, eic_pkg::TYPE_LO_IPV4, 4'd5, 16'h0000, eic_pkg::PROTO_UDP, 1'b1, 0);
		cut_frame(33);
		send_frame();
	endtask

	// mostly well-formed ipv4 with random fields, the rest broken or noise
	task automatic run_random_frames(input int idle_pct, input int stall_pct,
			input int min_frames, input int min_bytes);
		int          kind;
		int          i;
		int          first_frame;
		int          first_byte;
		bit          bcast;
		logic [3:0]  ihl;
		logic [15:0] frag;
		logic [7:0]  proto;
		bit          sum_ok;
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		first_frame = frames_sent;
		first_byte = bytes_sent;
		while (frames_sent - first_frame < min_frames || bytes_sent - first_byte < min_bytes) begin
			kind = $urandom_range(0, 99);
			bcast = ($urandom_range(0, 19) == 0);
			ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
			if ($urandom_range(0, 9) == 0)
				frag = 16'($urandom);
			else
				frag = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
			case ($urandom_range(0, 3))
				0: proto = eic_pkg::PROTO_ICMP;
				1: proto = 8'($urandom);
				default: proto = eic_pkg::PROTO_UDP;
			endcase
			sum_ok = ($urandom_range(0, 9) != 0);
			if (kind >= 92) begin
				frame_buf.delete();
				for (i = $urandom_range(1, 48); i > 0; i--)
					frame_buf.push_back(8'($urandom));
			end else begin
				if (kind >= 85)
					ihl = 4'($urandom_range(0, 4));
				build_ipv4(bcast, eic_pkg::TYPE_LO_IPV4, ihl, frag, proto, sum_ok,
					$urandom_range(0, 8));
				if ($urandom_range(0, 3) == 0)
					frame_buf[eic_pkg::POS_IP_START][7:4] = 4'($urandom);
				if (kind >= 55 && kind < 67) begin
					cut_frame($urandom_range(1, frame_buf.size() - 1));
				end else if (kind >= 67 && kind < 75) begin
					for (i = 0; i < 6; i++)
						frame_buf[i] = eic_pkg::BCAST_BYTE;
					case ($urandom_range(0, 2))
						0: frame_buf[eic_pkg::POS_TYPE_LO] = eic_pkg::TYPE_LO_ARP;
						1: frame_buf[eic_pkg::POS_TYPE_LO] = eic_pkg::TYPE_LO_IPV4;
						default: frame_buf[eic_pkg::POS_TYPE_LO] = 8'($urandom);
					endcase
				end else if (kind >= 75 && kind < 85) begin
					if ($urandom_range(0, 1))
						frame_buf[eic_pkg::POS_TYPE_LO] = 8'($urandom_range(1, 255));
					else
						frame_buf[eic_pkg::POS_TYPE_HI] = 8'($urandom);
				end
			end
			send_frame();
		end
	endtask

	// result sink: random backpressure, compare each result transfer
	always @(posedge clk) begin
		eic_pkg::class_result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_classes.size() == 0) begin
				$display("%0t: unexpected result transfer %08h", $time, m_axis_tdata);
				error_count++;
			end else begin
				exp_r = pending_classes.pop_front();
				if (m_axis_tdata[3:0] !== exp_r.cls || m_axis_tdata[11:4] !== exp_r.proto ||
						m_axis_tdata[15:12] !== exp_r.ihl || m_axis_tdata[31:16] !== exp_r.csum) begin
					$display("%0t: expected class %0d proto %02h ihl %0d csum %04h", $time,
						exp_r.cls, exp_r.proto, exp_r.ihl, exp_r.csum);
					$display("%0t: actual   class %0d proto %02h ihl %0d csum %04h", $time,
						m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[15:12],
						m_axis_tdata[31:16]);
					error_count++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// watchdog: too long without any transfer means the block is hung
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("ethernet_ipv4_frame_classifier verification failed");
			$finish;
		end
	end

	initial begin
		clear_tracker();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// source idling sometimes, sink stalling more
		send_idle_pct = 35;
		sink_stall_pct = 76;
		run_class_frames();
		hold_until_drained();

		// source idling more, sink stalling sometimes
		send_idle_pct = 76;
		sink_stall_pct = 35;
		run_short_ihl_frames();

		// no idling on either side
		send_idle_pct = 0;
		sink_stall_pct = 0;
		run_truncated_frames();
		run_random_frames(0, 0, 2, 40);

		// let every outstanding result arrive, then watch for strays
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_classes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("ethernet_ipv4_frame_classifier verification clean");
		else
			$display("ethernet_ipv4_frame_classifier verification failed");
		$finish;
	end

endmodule
